FILE: rtl/aesb_pkg.sv
`default_nettype none
package aesb_pkg;

  localparam int unsigned NumRegs = 5;
  localparam int unsigned RegIdxW = 3;
  localparam int unsigned MaxRounds = 14;

  localparam logic [RegIdxW-1:0] REG_KEY_256 = 3'd0;
  localparam logic [RegIdxW-1:0] REG_KEY_0_7 = 3'd1;
  localparam logic [RegIdxW-1:0] REG_KEY_8_15 = 3'd2;
  localparam logic [RegIdxW-1:0] REG_KEY_16_23 = 3'd3;
  localparam logic [RegIdxW-1:0] REG_KEY_24_31 = 3'd4;

  // Per-stage payload: cipher state plus the key schedule window.
  typedef struct packed {
    logic         k256;
    logic [127:0] st;
    logic [255:0] kw;    // last eight schedule words, w[i-8] in top word
    logic [7:0]   rcon;
  } stage_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  function automatic logic [7:0] gf_dbl(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

endpackage
`default_nettype wire

FILE: rtl/aesb_round.sv
`default_nettype none
// One pipeline stage: one cipher round plus the key words it needs next.
module aesb_round #(
  parameter int unsigned Round = 1
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            vld_in,
  input  wire aesb_pkg::stage_t d,
  output logic                 vld_out,
  output aesb_pkg::stage_t     q
);

  logic [127:0] st_mix;
  logic [127:0] rk;
  logic [255:0] kw_adv;
  logic [7:0]   rcon_adv;
  logic         last;
  aesb_pkg::stage_t q_nxt;
  logic [127:0] st_ss;
  logic [31:0]  w [8];
  logic [31:0]  t;

  // Byte n of the state sits at bits 127-8n.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        st_ss[127-8*(4*c+r) -: 8] =
          aesb_pkg::sbox(d.st[127-8*(4*((c+r)%4)+r) -: 8]);
      end
    end
  end

  always_comb begin
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      a0 = st_ss[127-32*c -: 8];
      a1 = st_ss[119-32*c -: 8];
      a2 = st_ss[111-32*c -: 8];
      a3 = st_ss[103-32*c -: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      st_mix[127-32*c -: 8] = a0 ^ al ^ aesb_pkg::gf_dbl(a0 ^ a1);
      st_mix[119-32*c -: 8] = a1 ^ al ^ aesb_pkg::gf_dbl(a1 ^ a2);
      st_mix[111-32*c -: 8] = a2 ^ al ^ aesb_pkg::gf_dbl(a2 ^ a3);
      st_mix[103-32*c -: 8] = a3 ^ al ^ aesb_pkg::gf_dbl(a3 ^ a0);
    end
  end

  // Advance the key schedule by four words. AES-128 keeps the upper half.
  always_comb begin
    for (int i = 0; i < 8; i++) w[i] = d.kw[255-32*i -: 32];
    rcon_adv = d.rcon;
    kw_adv   = d.kw;
    if (d.k256) begin
      // window w[i-8..i-1]; round Round needs words 4R..4R+3
      if (Round == 1) begin
        // round 1 uses w[4..7], already in the lower half of the window
        t = '0;
      end else begin
        if (Round % 2 == 0) begin
          t = aesb_pkg::sub_word({w[7][23:0], w[7][31:24]}) ^ {d.rcon, 24'h0};
          rcon_adv = aesb_pkg::gf_dbl(d.rcon);
        end else begin
          t = aesb_pkg::sub_word(w[7]);
        end
        kw_adv[255:128] = d.kw[127:0];
        kw_adv[127:96] = w[0] ^ t;
        kw_adv[95:64]  = w[1] ^ w[0] ^ t;
        kw_adv[63:32]  = w[2] ^ w[1] ^ w[0] ^ t;
        kw_adv[31:0]   = w[3] ^ w[2] ^ w[1] ^ w[0] ^ t;
      end
    end else begin
      t = aesb_pkg::sub_word({w[3][23:0], w[3][31:24]}) ^ {d.rcon, 24'h0};
      rcon_adv = aesb_pkg::gf_dbl(d.rcon);
      kw_adv[255:224] = w[0] ^ t;
      kw_adv[223:192] = w[1] ^ w[0] ^ t;
      kw_adv[191:160] = w[2] ^ w[1] ^ w[0] ^ t;
      kw_adv[159:128] = w[3] ^ w[2] ^ w[1] ^ w[0] ^ t;
    end
  end

  always_comb begin
    last = d.k256 ? (Round == 14) : (Round == 10);
    rk = d.k256 ? kw_adv[127:0] : kw_adv[255:128];
    q_nxt.k256 = d.k256;
    q_nxt.rcon = rcon_adv;
    q_nxt.kw   = kw_adv;
    if (Round > 10 && !d.k256) q_nxt.st = d.st;
    else q_nxt.st = (last ? st_ss : st_mix) ^ rk;
    if (Round > 10 && !d.k256) begin
      q_nxt.kw = d.kw;
      q_nxt.rcon = d.rcon;
    end
  end

  // Hold on stall, advance otherwise.
  always_ff @(posedge clk) begin
    if (!rst_n) vld_out <= 1'b0;
    else if (en) vld_out <= vld_in;
  end

  always_ff @(posedge clk) begin
    if (en) q <= q_nxt;
  end

endmodule
`default_nettype wire

FILE: rtl/aes_block_encrypt.sv
`default_nettype none
// AES-128/AES-256 block encryption, fully unrolled pipeline.
// Write the key and mode over cfg_ (index 0 mode, 1..4 key words, byte 0 of
// each word in bits 63:56) only while the pipeline is empty. Then stream
// plaintext beats on in_ (tdata = {plain_low, plain_high}, plain_high low);
// each gives one ciphertext beat on out_ in the same packing.
// Fifteen register stages in both key sizes: one for the initial key add,
// then fourteen round stages; in AES-128 mode stages 11..14 pass the state
// through. out_tvalid rises once the accepted block is registered in the
// last round stage. Throughput is one block per cycle while the output
// does not stall. Round keys are expanded alongside the data, four words per
// stage, so the key is sampled when the block enters.
// A stall on out_tready freezes every stage; in_tready drops as long as the
// output beat waits, nothing is lost or repeated.
// Reset clears all valid bits and the configuration registers to zero.
module aes_block_encrypt (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,   // plain_high[63:0], plain_low[127:64]
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [127:0]      out_tdata,  // cipher_high[63:0], cipher_low[127:64]
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [63:0]  cfg_data
);

  localparam int unsigned N = aesb_pkg::MaxRounds;

  logic        key_256_r;
  logic [63:0] key_r [4];
  logic        en;
  logic        vld [N+1];
  aesb_pkg::stage_t stg [N+1];
  aesb_pkg::stage_t s0_nxt;

  assign cfg_ready = 1'b1;

  // Hold configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_256_r <= 1'b0;
      for (int i = 0; i < 4; i++) key_r[i] <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        aesb_pkg::REG_KEY_256:   key_256_r <= cfg_data[0];
        aesb_pkg::REG_KEY_0_7:   key_r[0] <= cfg_data;
        aesb_pkg::REG_KEY_8_15:  key_r[1] <= cfg_data;
        aesb_pkg::REG_KEY_16_23: key_r[2] <= cfg_data;
        aesb_pkg::REG_KEY_24_31: key_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Whole pipeline moves unless the output beat is stuck.
  assign en = !out_tvalid || out_tready;
  assign in_tready = en;

  // Initial round key add.
  always_comb begin
    s0_nxt.k256 = key_256_r;
    s0_nxt.rcon = 8'h01;
    s0_nxt.kw   = {key_r[0], key_r[1], key_r[2], key_r[3]};
    s0_nxt.st   = {in_tdata[63:0], in_tdata[127:64]} ^ {key_r[0], key_r[1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld[0] <= 1'b0;
    else if (en) vld[0] <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (en) stg[0] <= s0_nxt;
  end

  for (genvar g = 1; g <= N; g++) begin : g_rnd
    aesb_round #(.Round(g)) u_round (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_in (vld[g-1]),
      .d      (stg[g-1]),
      .vld_out(vld[g]),
      .q      (stg[g])
    );
  end

  assign out_tvalid = vld[N];
  assign out_tdata  = {stg[N].st[63:0], stg[N].st[127:64]};

  // A stalled output beat holds its data.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output beat changed under stall");
  // Input is refused only while the output stalls.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input refused without stall");
  // An accepted beat reaches the first stage.
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld[0])
    else $error("accepted beat lost");

endmodule
`default_nettype wire
